### rtl/core/gre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and constants of the Gaussian response evaluator: payload
// widths, register indexes, fixed-point constants and the per-stage control
// record that travels down the pipeline.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int FUNC_W  = 2;
  localparam int DIST_W  = 16;
  localparam int REG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int K_W     = 3;
  localparam int HALV_N  = 4;

  // mode codes
  localparam logic [FUNC_W-1:0] FUNC_TRANS      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TRANS_LONG = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PAIR       = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TRANS_COEF      = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_COEF       = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAIR_COEF       = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRANS_NORM      = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRANS_LONG_NORM = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAIR_NORM       = 3'd5;

  localparam logic [REG_W-1:0] REG_RESET = 32'h0001_0000;

  // argument x is unsigned Q.40
  localparam logic [63:0] CUTOFF_Q40 = 64'd11434920928871;
  localparam logic [63:0] LN2_Q40    = 64'h0000_00B1_7217_F7D2;

  // polynomial coefficients, Q.30
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] C1_Q30  = 30'd1073600520;
  localparam logic [29:0] C2_Q30  = 30'd535037605;
  localparam logic [29:0] C3_Q30  = 30'd171297469;
  localparam logic [29:0] C4_Q30  = 30'd31529462;

  typedef struct packed {
    logic             zero;   // force response to zero
    logic             cut;    // argument beyond cut-off
    logic [K_W-1:0]   k;      // number of halvings
    logic [REG_W-1:0] norm;   // selected normalization
  } gre_ctl_t;

endpackage

### rtl/core/gre_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_in_if
// Input stream of the Gaussian response evaluator: mode and distances.
// ----------------------------------------------------------------------------
interface gre_in_if import gre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DIST_W-1:0] transversal_distance;
  logic signed [DIST_W-1:0] longitudinal_distance;

  modport source (output valid, output func, output transversal_distance,
                  output longitudinal_distance, input ready);
  modport sink   (input valid, input func, input transversal_distance,
                  input longitudinal_distance, output ready);
endinterface

### rtl/core/gre_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_out_if
// Result stream of the Gaussian response evaluator: response and cut-off flag.
// ----------------------------------------------------------------------------
interface gre_out_if import gre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REG_W-1:0] response;
  logic             cut_off;

  modport source (output valid, output response, output cut_off, input ready);
  modport sink   (input valid, input response, input cut_off, output ready);
endinterface

### rtl/core/gaussian_response_evaluator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_response_evaluator_core
// Normalized Gaussian response, norm * exp(-x), with a polynomial exp.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless a result waits at the output;
// each item passes a 15-stage pipeline: squared distances, coefficient
// products, the sum, cut-off and range reduction, four polynomial multiply
// stages, the polynomial close, four conditional squarings, the normalization
// product and the rounded, saturated output register. The whole pipeline holds
// while a result waits at the output and advances otherwise, so idle gaps and
// output stalls lose or repeat nothing. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and reset to 1.0 (Q16.16); write them only
// while no transfer is in flight.
// ----------------------------------------------------------------------------
module gaussian_response_evaluator_core import gre_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  gre_in_if.sink            in_ch,
  gre_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int NSTG = 15;

  // configuration registers
  logic [REG_W-1:0] trans_coef_r, long_coef_r, pair_coef_r;
  logic [REG_W-1:0] trans_norm_r, trans_long_norm_r, pair_norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_coef_r      <= REG_RESET;
      long_coef_r       <= REG_RESET;
      pair_coef_r       <= REG_RESET;
      trans_norm_r      <= REG_RESET;
      trans_long_norm_r <= REG_RESET;
      pair_norm_r       <= REG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRANS_COEF:      trans_coef_r      <= cfg_data;
        REG_LONG_COEF:       long_coef_r       <= cfg_data;
        REG_PAIR_COEF:       pair_coef_r       <= cfg_data;
        REG_TRANS_NORM:      trans_norm_r      <= cfg_data;
        REG_TRANS_LONG_NORM: trans_long_norm_r <= cfg_data;
        REG_PAIR_NORM:       pair_norm_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves together
  logic            adv;
  logic [NSTG-1:0] vld_r;
  gre_ctl_t        ctl_r   [NSTG];
  gre_ctl_t        ctl_nxt [NSTG];

  assign adv         = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= ctl_nxt[i];
      end
    end
  end

  // ---- stage 1: magnitudes squared, coefficient and norm selection ----
  logic [DIST_W-1:0] mag_t, mag_l;
  logic [30:0]       d2t_r, d2l_r;
  logic [REG_W-1:0]  ca_r, cb_r;
  logic [REG_W-1:0]  ca_nxt, cb_nxt;

  assign mag_t = in_ch.transversal_distance[DIST_W-1] ?
                 DIST_W'(-in_ch.transversal_distance) : in_ch.transversal_distance;
  assign mag_l = in_ch.longitudinal_distance[DIST_W-1] ?
                 DIST_W'(-in_ch.longitudinal_distance) : in_ch.longitudinal_distance;

  always_comb begin
    ctl_nxt[0] = '0;
    ca_nxt     = '0;
    cb_nxt     = '0;
    case (in_ch.func)
      FUNC_TRANS: begin
        ca_nxt          = trans_coef_r;
        ctl_nxt[0].norm = trans_norm_r;
      end
      FUNC_TRANS_LONG: begin
        ca_nxt          = trans_coef_r;
        cb_nxt          = long_coef_r;
        ctl_nxt[0].norm = trans_long_norm_r;
      end
      FUNC_PAIR: begin
        ca_nxt          = pair_coef_r;
        ctl_nxt[0].norm = pair_norm_r;
      end
      default: begin
        ctl_nxt[0].zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2t_r <= 31'(32'(mag_t) * 32'(mag_t));
      d2l_r <= 31'(32'(mag_l) * 32'(mag_l));
      ca_r  <= ca_nxt;
      cb_r  <= cb_nxt;
    end
  end

  // ---- stage 2: coefficient products ----
  logic [62:0] pa_r, pb_r;
  assign ctl_nxt[1] = ctl_r[0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= 63'(ca_r) * 63'(d2t_r);
      pb_r <= 63'(cb_r) * 63'(d2l_r);
    end
  end

  // ---- stage 3: argument sum ----
  logic [63:0] x_r;
  assign ctl_nxt[2] = ctl_r[1];

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= 64'(pa_r) + 64'(pb_r);
    end
  end

  // ---- stage 4: cut-off, halving count, reduced argument ----
  logic           cut4;
  logic [K_W-1:0] k4;
  logic [63:0]    xs4;
  logic [29:0]    y4_r;

  assign cut4 = x_r >= CUTOFF_Q40;

  always_comb begin
    k4 = '0;
    for (int j = 0; j < HALV_N; j++) begin
      if (x_r > (LN2_Q40 << j)) k4 = k4 + 1'b1;
    end
  end

  assign xs4 = x_r >> (4'(k4) + 4'd10);

  always_comb begin
    ctl_nxt[3]      = ctl_r[2];
    ctl_nxt[3].k    = k4;
    ctl_nxt[3].cut  = cut4 && !ctl_r[2].zero;
    ctl_nxt[3].zero = ctl_r[2].zero || cut4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y4_r <= xs4[29:0];
    end
  end

  // ---- stages 5 to 8: Horner multiplies ----
  logic [59:0] m5_r, m6_r, m7_r, m8_r;
  logic [29:0] y5_r, y6_r, y7_r;
  logic [29:0] t6, t7, t8;

  assign t6 = C3_Q30 - 30'(m5_r >> 30);
  assign t7 = C2_Q30 - 30'(m6_r >> 30);
  assign t8 = C1_Q30 - 30'(m7_r >> 30);

  assign ctl_nxt[4] = ctl_r[3];
  assign ctl_nxt[5] = ctl_r[4];
  assign ctl_nxt[6] = ctl_r[5];
  assign ctl_nxt[7] = ctl_r[6];

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_r <= 60'(y4_r) * 60'(C4_Q30);
      y5_r <= y4_r;
      m6_r <= 60'(y5_r) * 60'(t6);
      y6_r <= y5_r;
      m7_r <= 60'(y6_r) * 60'(t7);
      y7_r <= y6_r;
      m8_r <= 60'(y7_r) * 60'(t8);
    end
  end

  // ---- stage 9: polynomial close ----
  logic [30:0] p9_r;
  assign ctl_nxt[8] = ctl_r[7];

  always_ff @(posedge clk) begin
    if (adv) begin
      p9_r <= ONE_Q30 - 31'(m8_r >> 30);
    end
  end

  // ---- stages 10 to 13: square back once per halving ----
  logic [30:0] sq_r   [HALV_N];
  logic [30:0] sq_in  [HALV_N];
  logic [30:0] sq_nxt [HALV_N];
  logic [61:0] sq_prd [HALV_N];

  always_comb begin
    for (int j = 0; j < HALV_N; j++) begin
      sq_in[j]      = (j == 0) ? p9_r : sq_r[(j == 0) ? 0 : j - 1];
      sq_prd[j]     = 62'(sq_in[j]) * 62'(sq_in[j]) + 62'(1) * (62'(1) << 29);
      sq_nxt[j]     = (ctl_r[8 + j].k > K_W'(j)) ? 31'(sq_prd[j] >> 30) : sq_in[j];
    end
  end

  assign ctl_nxt[9]  = ctl_r[8];
  assign ctl_nxt[10] = ctl_r[9];
  assign ctl_nxt[11] = ctl_r[10];
  assign ctl_nxt[12] = ctl_r[11];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < HALV_N; j++) begin
        sq_r[j] <= sq_nxt[j];
      end
    end
  end

  // ---- stage 14: exp factor times normalization ----
  logic [16:0] e14;
  logic [48:0] ne_r;

  assign e14         = 17'((32'(sq_r[HALV_N-1]) + 32'd8192) >> 14);
  assign ctl_nxt[13] = ctl_r[12];

  always_ff @(posedge clk) begin
    if (adv) begin
      ne_r <= 49'(ctl_r[12].norm) * 49'(e14);
    end
  end

  // ---- stage 15: round, saturate, output register ----
  logic [32:0]      rnd15;
  logic [REG_W-1:0] resp_r, resp_nxt;

  assign rnd15       = 33'((ne_r + 49'd32768) >> 16);
  assign ctl_nxt[14] = ctl_r[13];

  always_comb begin
    if (ctl_r[13].zero) begin
      resp_nxt = '0;
    end else if (rnd15[32]) begin
      resp_nxt = '1;
    end else begin
      resp_nxt = rnd15[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      resp_r <= resp_nxt;
    end
  end

  assign out_ch.valid    = vld_r[NSTG-1];
  assign out_ch.response = resp_r;
  assign out_ch.cut_off  = ctl_r[NSTG-1].cut;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gaussian_response_evaluator_core. A queue-fed driver
// sends distance samples under random gaps. A monitor with random back-pressure
// checks each result against a bit-exact fixed-point model of norm * exp(-x).
// The run walks through default, extreme and random register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import gre_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int PIPE_LATENCY   = 15;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LINES   = 40;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DIST_W-1:0] tdist;
    logic signed [DIST_W-1:0] ldist;
  } sample_t;

  typedef struct packed {
    logic [REG_W-1:0] response;
    logic             cut_off;
  } response_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  gre_in_if  in_ch ();
  gre_out_if out_ch ();

  gaussian_response_evaluator_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [REG_W-1:0] reg_shadow [0:5];
  sample_t          samples_to_send [$];
  response_word_t   responses_due [$];
  sample_t          in_flight;
  int               send_gap;
  int               recv_wait;
  int unsigned      results_seen;
  int unsigned      mismatch_count;
  int unsigned      quiet_cycles;
  bit               tx_calm;
  bit               rx_calm;
  bit               long_hold_req;
  bit               long_hold_done;

  // Q3.12 distance squared, exact in Q6.24
  function automatic logic [63:0] square_q24(input logic [DIST_W-1:0] d);
    logic [63:0] mag;
    mag = 64'(d[DIST_W-1] ? (17'h10000 - {1'b0, d}) : {1'b0, d});
    return mag * mag;
  endfunction

  function automatic response_word_t gaussian_response(input sample_t s);
    logic [63:0]      arg;
    logic [63:0]      y;
    logic [63:0]      poly;
    logic [63:0]      factor;
    logic [63:0]      scaled;
    logic [REG_W-1:0] norm;
    int unsigned      halvings;
    response_word_t   r;
    r = '0;
    case (s.func)
      FUNC_TRANS: begin
        arg  = 64'(reg_shadow[REG_TRANS_COEF]) * square_q24(s.tdist);
        norm = reg_shadow[REG_TRANS_NORM];
      end
      FUNC_TRANS_LONG: begin
        arg  = 64'(reg_shadow[REG_TRANS_COEF]) * square_q24(s.tdist)
             + 64'(reg_shadow[REG_LONG_COEF]) * square_q24(s.ldist);
        norm = reg_shadow[REG_TRANS_LONG_NORM];
      end
      FUNC_PAIR: begin
        arg  = 64'(reg_shadow[REG_PAIR_COEF]) * square_q24(s.tdist);
        norm = reg_shadow[REG_PAIR_NORM];
      end
      default: return r;
    endcase
    if (arg >= CUTOFF_Q40) begin
      r.cut_off = 1'b1;
      return r;
    end
    // range-reduce until the argument is at most ln2
    halvings = 0;
    while (halvings < HALV_N && arg > (LN2_Q40 << halvings))
      halvings++;
    y    = arg >> (halvings + 10);
    poly = 64'(C4_Q30);
    poly = 64'(C3_Q30) - ((y * poly) >> 30);
    poly = 64'(C2_Q30) - ((y * poly) >> 30);
    poly = 64'(C1_Q30) - ((y * poly) >> 30);
    poly = 64'(ONE_Q30) - ((y * poly) >> 30);
    repeat (halvings) poly = (poly * poly + (64'd1 << 29)) >> 30;
    factor = (poly + (64'd1 << 13)) >> 14;
    scaled = (64'(norm) * factor + (64'd1 << 15)) >> 16;
    r.response = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[REG_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [REG_W-1:0] got,
                                 input logic [REG_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  // driver: one sample per transfer, random gap after each unless tx_calm is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        responses_due.push_back(gaussian_response(in_flight));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (samples_to_send.size() != 0) begin
          in_flight = samples_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= in_flight.func;
          in_ch.transversal_distance <= in_flight.tdist;
          in_ch.longitudinal_distance <= in_flight.ldist;
          send_gap <= draw_wait(tx_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, then stall ready for a drawn count
  always @(posedge clk) begin : result_check
    response_word_t want;
    int unsigned    w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_ch.valid && out_ch.ready) begin
        if (responses_due.size() == 0) begin
          report_mismatch("unexpected result", out_ch.response, '0);
        end else begin
          want = responses_due.pop_front();
          if (out_ch.response !== want.response)
            report_mismatch("response", out_ch.response, want.response);
          if (out_ch.cut_off !== want.cut_off)
            report_mismatch("cut_off", 32'(out_ch.cut_off), 32'(want.cut_off));
        end
        results_seen++;
        if (long_hold_req && !long_hold_done) begin
          w = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          w = draw_wait(rx_calm);
        end
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        recv_wait <= w - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    reg_shadow[idx] = value;
  endtask

  task automatic load_registers(input logic [REG_W-1:0] tc, lc, pc, tn, tln, pn);
    write_reg(REG_TRANS_COEF, tc);
    write_reg(REG_LONG_COEF, lc);
    write_reg(REG_PAIR_COEF, pc);
    write_reg(REG_TRANS_NORM, tn);
    write_reg(REG_TRANS_LONG_NORM, tln);
    write_reg(REG_PAIR_NORM, pn);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_sample(input logic [FUNC_W-1:0] f, input int t, input int l);
    sample_t s;
    s.func  = f;
    s.tdist = t[DIST_W-1:0];
    s.ldist = l[DIST_W-1:0];
    samples_to_send.push_back(s);
  endtask

  function automatic logic [DIST_W-1:0] random_distance();
    logic [DIST_W-1:0] mag;
    if ($urandom_range(0, 2) == 0)
      return DIST_W'($urandom);
    // mostly short distances so the argument stays below the cut-off
    mag = DIST_W'($urandom_range(0, 12000));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic add_random_samples(input int count);
    sample_t     s;
    int unsigned pick;
    repeat (count) begin
      pick   = $urandom_range(0, 9);
      s.func = (pick < 3) ? FUNC_TRANS : (pick < 6) ? FUNC_TRANS_LONG :
               (pick < 9) ? FUNC_PAIR : FUNC_UNUSED;
      s.tdist = random_distance();
      s.ldist = random_distance();
      samples_to_send.push_back(s);
    end
  endtask

  function automatic logic [REG_W-1:0] pick_coef();
    if ($urandom_range(0, 7) == 0)
      return $urandom;
    return $urandom_range(1024, 40000);
  endfunction

  function automatic logic [REG_W-1:0] pick_norm();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  // hold until every sample is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || in_ch.valid || responses_due.size() != 0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_TRANS;
    in_ch.transversal_distance = '0;
    in_ch.longitudinal_distance = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TRANS_COEF;
    cfg_data = '0;
    for (int i = 0; i < 6; i++) reg_shadow[i] = REG_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes, unused selector, cut-off and halving edges
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    add_sample(FUNC_TRANS, 0, 0);
    add_sample(FUNC_TRANS_LONG, 0, 0);
    add_sample(FUNC_PAIR, 0, 0);
    add_sample(FUNC_UNUSED, 0, 0);
    add_sample(FUNC_UNUSED, 32767, -32768);
    add_sample(FUNC_TRANS, 32767, 0);
    add_sample(FUNC_TRANS, -32768, 0);
    add_sample(FUNC_PAIR, -32768, 0);
    add_sample(FUNC_TRANS_LONG, 32767, 32767);
    add_sample(FUNC_TRANS_LONG, -32768, -32768);
    add_sample(FUNC_TRANS_LONG, 0, -32768);
    add_sample(FUNC_TRANS, -1, 0);
    add_sample(FUNC_TRANS, 13209, 0);
    add_sample(FUNC_TRANS, 13210, 0);
    add_sample(FUNC_TRANS, -13210, 0);
    add_sample(FUNC_PAIR, 13209, 0);
    add_sample(FUNC_TRANS, 3410, 0);
    add_sample(FUNC_TRANS, 3411, 0);
    add_sample(FUNC_TRANS, 4822, 0);
    add_sample(FUNC_TRANS, 4823, 0);
    add_sample(FUNC_TRANS, 6820, 0);
    add_sample(FUNC_TRANS, 6821, 0);
    add_sample(FUNC_TRANS, 9645, 0);
    add_sample(FUNC_TRANS, 9646, 0);
    add_sample(FUNC_TRANS_LONG, 9340, 9340);
    add_sample(FUNC_TRANS_LONG, 9341, -9341);
    tx_calm = 1'b0;
    add_random_samples(60);
    wait_drained();

    // zero coefficients, full-scale norms
    rx_calm = 1'b1;
    load_registers('0, '0, '0, '1, '1, '1);
    add_random_samples(50);
    wait_drained();

    // full-scale coefficients, zero norms
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    load_registers('1, '1, '1, '0, '0, '0);
    add_random_samples(40);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      tx_calm = (ph == 0) || (ph == 2);
      rx_calm = (ph == 3);
      // stall the result side long enough to back up the input
      if (ph == 0) long_hold_req <= 1'b1;
      load_registers(pick_coef(), pick_coef(), pick_coef(),
                     pick_norm(), pick_norm(), pick_norm());
      add_random_samples(95);
      wait_drained();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (responses_due.size() != 0)
      report_mismatch("missing results", '0, 32'(responses_due.size()));
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
